// ===== hdl/lkvt_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvt_pkg
// Shared types, constants and helpers of the LRU key-value table.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int AGE_W   = 64;
    localparam int STAT_W  = 32;
    localparam int CNT_W   = 5;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_COMMIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_kv;
        logic             wr_age;
        logic [IDX_W-1:0] wr_idx;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [AGE_W-1:0] age;
    } t_mem_req;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [AGE_W-1:0] age;
    } t_mem_rsp;

    typedef struct packed {
        logic              status;
        logic [VAL_W-1:0]  found_value;
        logic [STAT_W-1:0] hits;
        logic [STAT_W-1:0] misses;
        logic [STAT_W-1:0] evictions;
        logic [CNT_W-1:0]  occupied;
    } t_result;

    // Highest slot index in use for a given capacity register value.
    function automatic logic [IDX_W-1:0] last_slot(input logic [CAP_W-1:0] cap);
        logic [IDX_W-1:0] res;
        if (cap == '0) begin
            res = '0;
        end else if (int'(cap) > ENTRIES) begin
            res = IDX_W'(ENTRIES - 1);
        end else begin
            res = IDX_W'(int'(cap) - 1);
        end
        return res;
    endfunction

    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lkvt_store.sv =====
// ----------------------------------------------------------------------------
// lkvt_store
// Key, value and age memories with one write port and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvt_store
    import lkvt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_mem_rsp      o_rsp
);

    logic [KEY_W-1:0] r_key_mem [ENTRIES];
    logic [VAL_W-1:0] r_val_mem [ENTRIES];
    logic [AGE_W-1:0] r_age_mem [ENTRIES];
    t_mem_rsp         r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_kv) begin
            r_key_mem[i_req.wr_idx] <= i_req.key;
            r_val_mem[i_req.wr_idx] <= i_req.value;
        end
        if (i_req.wr_age) begin
            r_age_mem[i_req.wr_idx] <= i_req.age;
        end
        if (i_req.rd_en) begin
            r_rsp.key   <= r_key_mem[i_req.rd_idx];
            r_rsp.value <= r_val_mem[i_req.rd_idx];
            r_rsp.age   <= r_age_mem[i_req.rd_idx];
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// ===== hdl/lkvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lkvt_ctrl
// Request sequencer: for a put, get or remove, scans the slots through one key
// and age compare unit, then commits the update; results are held until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvt_ctrl
    import lkvt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [1:0]       i_op,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [VAL_W-1:0] i_value,
    input  wire logic [IDX_W-1:0] i_last,
    input  wire logic             i_out_free,
    input  wire t_mem_rsp         i_mem_rsp,
    output t_mem_req              o_mem_req,
    output logic                  o_busy,
    output logic                  o_res_load,
    output t_result               o_result
);

    t_state            r_state;
    t_state            n_state;
    t_op               r_op;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_value;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_last;
    logic              r_pv;
    logic [IDX_W-1:0]  r_pidx;
    logic              r_match;
    logic [IDX_W-1:0]  r_midx;
    logic [VAL_W-1:0]  r_mval;
    logic              r_free;
    logic [IDX_W-1:0]  r_fidx;
    logic              r_have_old;
    logic [IDX_W-1:0]  r_oidx;
    logic [AGE_W-1:0]  r_oage;
    logic [ENTRIES-1:0] r_valid;
    logic [AGE_W-1:0]  r_clock;
    logic [CNT_W-1:0]  r_live;
    logic [STAT_W-1:0] r_hits;
    logic [STAT_W-1:0] r_misses;
    logic [STAT_W-1:0] r_evicts;
    logic              r_status;
    logic [VAL_W-1:0]  r_found;

    logic              hit_now;
    logic              free_now;
    logic              older_now;
    logic [IDX_W-1:0]  put_slot;

    assign hit_now   = r_pv && r_valid[r_pidx] && (i_mem_rsp.key == r_key);
    assign free_now  = r_pv && !r_valid[r_pidx];
    assign older_now = r_pv && r_valid[r_pidx] && (!r_have_old || (i_mem_rsp.age < r_oage));
    assign put_slot  = r_match ? r_midx : (r_free ? r_fidx : r_oidx);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (t_op'(i_op) == OP_CLEAR) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_last) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL:   n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_DONE;
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_mem_req        = '0;
        o_mem_req.rd_en  = (r_state == ST_SCAN);
        o_mem_req.rd_idx = r_idx;
        o_mem_req.key    = r_key;
        o_mem_req.value  = r_value;
        o_mem_req.age    = r_clock + 1'b1;
        o_mem_req.wr_idx = put_slot;
        if (r_state == ST_COMMIT) begin
            if (r_op == OP_PUT) begin
                o_mem_req.wr_kv  = 1'b1;
                o_mem_req.wr_age = 1'b1;
            end else if (r_op == OP_GET) begin
                o_mem_req.wr_age = r_match;
            end
        end
        o_busy     = (r_state != ST_IDLE);
        o_res_load = (r_state == ST_DONE) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pv     <= 1'b0;
            r_valid  <= '0;
            r_clock  <= '0;
            r_live   <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_op       <= t_op'(i_op);
                r_key      <= i_key;
                r_value    <= i_value;
                r_idx      <= '0;
                r_last     <= i_last;
                r_pv       <= 1'b0;
                r_match    <= 1'b0;
                r_free     <= 1'b0;
                r_have_old <= 1'b0;
                r_status   <= 1'b0;
                r_found    <= '0;
                if (t_op'(i_op) == OP_CLEAR) begin
                    r_valid <= '0;
                    r_live  <= '0;
                end
            end
            if (r_state == ST_SCAN) begin
                r_idx  <= r_idx + 1'b1;
                r_pv   <= 1'b1;
                r_pidx <= r_idx;
            end else if (r_state == ST_TAIL) begin
                r_pv <= 1'b0;
            end
            if (hit_now && !r_match) begin
                r_match <= 1'b1;
                r_midx  <= r_pidx;
                r_mval  <= i_mem_rsp.value;
            end
            if (free_now && !r_free) begin
                r_free <= 1'b1;
                r_fidx <= r_pidx;
            end
            if (older_now) begin
                r_have_old <= 1'b1;
                r_oidx     <= r_pidx;
                r_oage     <= i_mem_rsp.age;
            end
            if (r_state == ST_COMMIT) begin
                case (r_op)
                    OP_PUT: begin
                        r_valid[put_slot] <= 1'b1;
                        r_clock           <= r_clock + 1'b1;
                        if (!r_match) begin
                            if (r_free) begin
                                r_live <= r_live + 1'b1;
                            end else begin
                                r_evicts <= sat_inc(r_evicts);
                            end
                        end
                    end
                    OP_GET: begin
                        if (r_match) begin
                            r_hits  <= sat_inc(r_hits);
                            r_clock <= r_clock + 1'b1;
                            r_found <= r_mval;
                        end else begin
                            r_misses <= sat_inc(r_misses);
                            r_status <= 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_match) begin
                            r_valid[r_midx] <= 1'b0;
                            if (r_live != '0) begin
                                r_live <= r_live - 1'b1;
                            end
                        end else begin
                            r_status <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_result = '{
        status:      r_status,
        found_value: r_found,
        hits:        r_hits,
        misses:      r_misses,
        evictions:   r_evicts,
        occupied:    r_live
    };

endmodule

`default_nettype wire

// ===== hdl/lru_key_value_table_unit.sv =====
// A put, get or remove reads the slots in use (1 to 16) one per cycle through the
// single key and age compare, then passes the tail and commit states; a clear goes
// straight to the done state. A new request is stalled until the previous result
// has been handed to the output register, which holds it while the output stalls.
// Reset is synchronous: valid bits, use clock, counters and occupancy clear at once,
// and the capacity returns to 16. The key, value and age memories are not cleared.
// ----------------------------------------------------------------------------
// lru_key_value_table_unit
// Fully associative key-value table with least-recently-used replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_table_unit
    import lkvt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CAP_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_op,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [VAL_W-1:0]  i_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_status,
    output logic [VAL_W-1:0]       o_found_value,
    output logic [STAT_W-1:0]      o_hits_total,
    output logic [STAT_W-1:0]      o_misses_total,
    output logic [STAT_W-1:0]      o_evictions_total,
    output logic [CNT_W-1:0]       o_occupied_entries
);

    logic [CAP_W-1:0] r_capacity;
    logic             r_out_valid;
    t_result          r_result;

    logic     start;
    logic     out_free;
    logic     busy;
    logic     res_load;
    t_result  result;
    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy;
    assign start       = i_in_valid && !busy;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_result <= result;
        end
    end

    lkvt_store u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    lkvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_op       (i_op),
        .i_key      (i_key),
        .i_value    (i_value),
        .i_last     (last_slot(r_capacity)),
        .i_out_free (out_free),
        .i_mem_rsp  (mem_rsp),
        .o_mem_req  (mem_req),
        .o_busy     (busy),
        .o_res_load (res_load),
        .o_result   (result)
    );

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_result.status;
    assign o_found_value      = r_result.found_value;
    assign o_hits_total       = r_result.hits;
    assign o_misses_total     = r_result.misses;
    assign o_evictions_total  = r_result.evictions;
    assign o_occupied_entries = r_result.occupied;

endmodule

`default_nettype wire

// ===== hdl/lkvt_checker.sv =====
// ----------------------------------------------------------------------------
// lkvt_checker
// Port-level checks of the LRU key-value table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvt_checker
    import lkvt_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic              o_status,
    input wire logic [VAL_W-1:0]  o_found_value,
    input wire logic [STAT_W-1:0] o_hits_total,
    input wire logic [STAT_W-1:0] o_misses_total,
    input wire logic [STAT_W-1:0] o_evictions_total,
    input wire logic [CNT_W-1:0]  o_occupied_entries
);

    a_occupancy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_occupied_entries) <= ENTRIES))
        else $error("occupancy above table size");

    a_miss_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_found_value == '0))
        else $error("value returned with a not-found status");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("new request taken while one is in progress");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_found_value) && $stable(o_hits_total)
            && $stable(o_misses_total) && $stable(o_evictions_total)
            && $stable(o_occupied_entries)))
        else $error("stalled result changed");

endmodule

bind lru_key_value_table_unit lkvt_checker u_lkvt_checker (.*);

`default_nettype wire

// ===== dv/lkvt_result_checker.sv =====
// ----------------------------------------------------------------------------
// lkvt_result_checker
// Watches the request, result and capacity channels of the LRU key-value
// table. It keeps its own copy of the table and predicts every result, then
// compares each returned result field by field, in order of transfer.
// ----------------------------------------------------------------------------
module lkvt_result_checker
    import lkvt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [CAP_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic [1:0]        i_op,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic              i_status,
    input  wire logic [VAL_W-1:0]  i_found_value,
    input  wire logic [STAT_W-1:0] i_hits_total,
    input  wire logic [STAT_W-1:0] i_misses_total,
    input  wire logic [STAT_W-1:0] i_evictions_total,
    input  wire logic [CNT_W-1:0]  i_occupied_entries,
    output int                     o_mismatch_count,
    output int                     o_pending_results,
    output int                     o_results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [KEY_W-1:0]  key_tab [ENTRIES];
    logic [VAL_W-1:0]  val_tab [ENTRIES];
    logic [AGE_W-1:0]  age_tab [ENTRIES];
    bit                live_tab [ENTRIES];
    logic [AGE_W-1:0]  use_clock;
    logic [CNT_W-1:0]  live_count;
    logic [STAT_W-1:0] hit_cnt;
    logic [STAT_W-1:0] miss_cnt;
    logic [STAT_W-1:0] evict_cnt;
    logic [CAP_W-1:0]  capacity;
    t_result           reply_queue [$];

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        o_mismatch_count++;
        $display("[%0t] %s differs: got %h, expected %h", $realtime, what, seen, wanted);
    endtask

    function automatic int find_slot(input logic [KEY_W-1:0] key, input int span);
        int hit;
        hit = -1;
        for (int i = span - 1; i >= 0; i--) begin
            if (live_tab[i] && key_tab[i] == key) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    function automatic t_result serve_request(input t_op op, input logic [KEY_W-1:0] key,
                                              input logic [VAL_W-1:0] value);
        t_result          r;
        int               span;
        int               slot;
        bit               have_free;
        logic [AGE_W-1:0] oldest;
        r = '0;
        span = (capacity == '0) ? 1 :
               ((int'(capacity) > ENTRIES) ? ENTRIES : int'(capacity));
        slot = find_slot(key, span);
        case (op)
            OP_PUT: begin
                if (slot < 0) begin
                    slot = 0;
                    have_free = 1'b0;
                    oldest = age_tab[0];
                    for (int i = 0; i < span && !have_free; i++) begin
                        if (!live_tab[i]) begin
                            slot = i;
                            have_free = 1'b1;
                        end else if (age_tab[i] < oldest) begin
                            oldest = age_tab[i];
                            slot = i;
                        end
                    end
                    if (have_free) begin
                        live_count++;
                    end else if (evict_cnt != '1) begin
                        evict_cnt++;
                    end
                end
                key_tab[slot] = key;
                val_tab[slot] = value;
                use_clock++;
                age_tab[slot] = use_clock;
                live_tab[slot] = 1'b1;
            end
            OP_GET: begin
                if (slot < 0) begin
                    r.status = 1'b1;
                    if (miss_cnt != '1) begin
                        miss_cnt++;
                    end
                end else begin
                    if (hit_cnt != '1) begin
                        hit_cnt++;
                    end
                    use_clock++;
                    age_tab[slot] = use_clock;
                    r.found_value = val_tab[slot];
                end
            end
            OP_REMOVE: begin
                if (slot < 0) begin
                    r.status = 1'b1;
                end else begin
                    live_tab[slot] = 1'b0;
                    age_tab[slot] = '0;
                    if (live_count != '0) begin
                        live_count--;
                    end
                end
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    live_tab[i] = 1'b0;
                    age_tab[i] = '0;
                end
                live_count = '0;
            end
        endcase
        r.hits = hit_cnt;
        r.misses = miss_cnt;
        r.evictions = evict_cnt;
        r.occupied = live_count;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result seen;
        t_result wanted;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                key_tab[i] = '0;
                val_tab[i] = '0;
                age_tab[i] = '0;
                live_tab[i] = 1'b0;
            end
            use_clock = '0;
            live_count = '0;
            hit_cnt = '0;
            miss_cnt = '0;
            evict_cnt = '0;
            capacity = CAP_RESET;
            reply_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                capacity = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                seen.status = i_status;
                seen.found_value = i_found_value;
                seen.hits = i_hits_total;
                seen.misses = i_misses_total;
                seen.evictions = i_evictions_total;
                seen.occupied = i_occupied_entries;
                o_results_checked++;
                if (reply_queue.size() == 0) begin
                    report_mismatch("unrequested result", seen.found_value, '0);
                end else begin
                    wanted = reply_queue.pop_front();
                    if (seen.status !== wanted.status) begin
                        report_mismatch("status", seen.status, wanted.status);
                    end
                    if (seen.found_value !== wanted.found_value) begin
                        report_mismatch("found_value", seen.found_value, wanted.found_value);
                    end
                    if (seen.hits !== wanted.hits) begin
                        report_mismatch("hits_total", seen.hits, wanted.hits);
                    end
                    if (seen.misses !== wanted.misses) begin
                        report_mismatch("misses_total", seen.misses, wanted.misses);
                    end
                    if (seen.evictions !== wanted.evictions) begin
                        report_mismatch("evictions_total", seen.evictions, wanted.evictions);
                    end
                    if (seen.occupied !== wanted.occupied) begin
                        report_mismatch("occupied_entries", seen.occupied, wanted.occupied);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                reply_queue.push_back(serve_request(t_op'(i_op), i_key, i_value));
            end
        end
        o_pending_results = reply_queue.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random put, get, remove and clear requests into the
// LRU key-value table under several capacity settings, with bursty requests
// and random result stalls, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lkvt_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CAP_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    t_op               in_op = OP_PUT;
    logic [KEY_W-1:0]  in_key = '0;
    logic [VAL_W-1:0]  in_value = '0;
    logic              out_stall = 1'b0;

    logic              cfg_ready;
    logic              in_stall;
    logic              out_valid;
    logic              status;
    logic [VAL_W-1:0]  found_value;
    logic [STAT_W-1:0] hits_total;
    logic [STAT_W-1:0] misses_total;
    logic [STAT_W-1:0] evictions_total;
    logic [CNT_W-1:0]  occupied_entries;

    int mismatch_count;
    int pending_results;
    int results_checked;

    int burst_left = 4;
    int stall_hold = 0;
    int free_hold = 0;
    int idle_cycles = 0;
    int cap_writes = 0;
    int op_tally [4] = '{0, 0, 0, 0};

    always #6 clk = ~clk;

    lru_key_value_table_unit dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_op               (in_op),
        .i_key              (in_key),
        .i_value            (in_value),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_status           (status),
        .o_found_value      (found_value),
        .o_hits_total       (hits_total),
        .o_misses_total     (misses_total),
        .o_evictions_total  (evictions_total),
        .o_occupied_entries (occupied_entries)
    );

    lkvt_result_checker result_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_op               (in_op),
        .i_key              (in_key),
        .i_value            (in_value),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_status           (status),
        .i_found_value      (found_value),
        .i_hits_total       (hits_total),
        .i_misses_total     (misses_total),
        .i_evictions_total  (evictions_total),
        .i_occupied_entries (occupied_entries),
        .o_mismatch_count   (mismatch_count),
        .o_pending_results  (pending_results),
        .o_results_checked  (results_checked)
    );

    // The result side alternates short stall runs with free stretches, some of them long.
    always @(negedge clk) begin
        if (free_hold == 0 && stall_hold == 0) begin
            free_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(0, 6);
            stall_hold = $urandom_range(1, 12);
        end
        if (free_hold > 0) begin
            free_hold--;
            out_stall <= 1'b0;
        end else begin
            stall_hold--;
            out_stall <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic issue(input t_op op, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value);
        in_valid <= 1'b1;
        in_op <= op;
        in_key <= key;
        in_value <= value;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        op_tally[int'(op)]++;
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 6);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (pending_results != 0);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        cap_writes++;
    endtask

    initial begin : stimulus
        logic [KEY_W-1:0] key_pool [24];
        logic [CAP_W-1:0] cap_plan [10];
        logic [KEY_W-1:0] key;
        t_op              op;
        int               span;
        int               pool_size;
        int               roll;
        cap_plan = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd31, 5'd5, 5'd16, 5'd12, 5'd2};
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Empty table, extreme keys and values, replacement, removal and clear.
        issue(OP_GET, '0, '0);
        issue(OP_REMOVE, '0, '1);
        issue(OP_PUT, '0, '1);
        issue(OP_PUT, '1, '0);
        issue(OP_GET, '1, '1);
        issue(OP_GET, '0, '0);
        issue(OP_PUT, '0, 64'h5555_5555_5555_5555);
        issue(OP_GET, '0, '0);
        issue(OP_REMOVE, '1, '0);
        issue(OP_REMOVE, '1, '0);
        issue(OP_CLEAR, '1, '1);
        issue(OP_GET, '0, '0);

        // A single slot forces eviction on every new key once it is filled; zero behaves as one.
        set_capacity(5'd1);
        issue(OP_PUT, 64'hA5A5_A5A5_A5A5_A5A5, 64'h1);
        issue(OP_PUT, 64'h5A5A_5A5A_5A5A_5A5A, 64'h2);
        issue(OP_GET, 64'hA5A5_A5A5_A5A5_A5A5, '0);
        issue(OP_GET, 64'h5A5A_5A5A_5A5A_5A5A, '0);
        set_capacity(5'd0);
        issue(OP_PUT, 64'h0123_4567_89AB_CDEF, 64'h3);

        // Shrinking hides upper slots from lookup and replacement; growing exposes them again.
        set_capacity(5'd4);
        issue(OP_PUT, 64'd1, 64'h11);
        issue(OP_PUT, 64'd2, 64'h22);
        issue(OP_PUT, 64'd3, 64'h33);
        issue(OP_GET, 64'd1, '0);
        set_capacity(5'd2);
        issue(OP_PUT, 64'd9, 64'h99);
        issue(OP_GET, 64'd3, '0);
        issue(OP_REMOVE, 64'd2, '0);
        set_capacity(5'd31);
        issue(OP_GET, 64'd3, '0);
        issue(OP_REMOVE, 64'd2, '0);

        for (int p = 0; p < 10; p++) begin
            set_capacity(cap_plan[p]);
            span = (cap_plan[p] == '0) ? 1 :
                   ((int'(cap_plan[p]) > ENTRIES) ? ENTRIES : int'(cap_plan[p]));
            pool_size = span + $urandom_range(1, 6);
            for (int k = 0; k < pool_size; k++) begin
                key_pool[k] = {$urandom, $urandom};
            end
            for (int i = 0; i < 90; i++) begin
                if (i == 45 && p % 2 == 0) begin
                    drain();
                end
                roll = $urandom_range(0, 99);
                op = (roll < 45) ? OP_PUT : (roll < 80) ? OP_GET :
                     (roll < 97) ? OP_REMOVE : OP_CLEAR;
                key = ($urandom_range(0, 99) < 6) ? {$urandom, $urandom}
                                                  : key_pool[$urandom_range(0, pool_size - 1)];
                issue(op, key, {$urandom, $urandom});
            end
        end

        drain();
        repeat (24) @(negedge clk);
        $display("Covered %0d requests: %0d puts, %0d gets, %0d removes, %0d clears.",
                 op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
                 op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
        $display("%0d capacity writes between 0 and 31; %0d results compared.",
                 cap_writes, results_checked);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lkvt_pkg.sv
hdl/lkvt_store.sv
hdl/lkvt_ctrl.sv
hdl/lru_key_value_table_unit.sv
hdl/lkvt_checker.sv
dv/lkvt_result_checker.sv
dv/tb_top.sv
